// ----- src/alu16f_pkg.sv -----
// Package for the 16-bit ALU with N, Z, C and V flags.
// Holds the operation and condition codes, the flag type and the byte masks.
// Depends on nothing.
package alu16f_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_ADC   = 4'd2,
        OP_SBC   = 4'd3,
        OP_AND   = 4'd4,
        OP_OR    = 4'd5,
        OP_XOR   = 4'd6,
        OP_LSL   = 4'd7,
        OP_LSR   = 4'd8,
        OP_ASR   = 4'd9,
        OP_MOVL  = 4'd10,
        OP_MOVH  = 4'd11,
        OP_PASSB = 4'd12,
        OP_PASSA = 4'd13,
        OP_NONE  = 4'd14
    } alu_func_t;

    typedef enum logic [2:0] {
        COND_EQ = 3'd0,
        COND_NE = 3'd1,
        COND_GE = 3'd2,
        COND_GT = 3'd3,
        COND_LT = 3'd4,
        COND_LE = 3'd5,
        COND_CS = 3'd6,
        COND_CC = 3'd7
    } cond_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    localparam logic [15:0] HIGH_BYTE = 16'hFF00;
    localparam logic [15:0] LOW_BYTE  = 16'h00FF;

endpackage

// ----- src/alu16f_exec.sv -----
// Combinational execute logic: result, next flags and condition test.
// Depends on alu16f_pkg.
module alu16f_exec
    import alu16f_pkg::*;
(
    input  logic [3:0]  alu_function,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic        update_flags,
    input  logic [2:0]  condition,
    input  flags_t      flags_old,
    output logic [15:0] result,
    output flags_t      flags_new,
    output logic        cond_holds
);

    logic        arith;
    logic [15:0] b_eff;
    logic        carry_in;
    logic [16:0] sum;
    logic [15:0] logic_res;
    logic        big_shift;
    logic [3:0]  shamt;

    assign big_shift = |operand_b[15:4];
    assign shamt     = operand_b[3:0];

    always_comb
    begin
        arith     = 1'b0;
        b_eff     = operand_b;
        carry_in  = 1'b0;
        logic_res = '0;
        unique case (alu_function)
            OP_ADD:
            begin
                arith = 1'b1;
            end
            OP_SUB:
            begin
                arith    = 1'b1;
                b_eff    = ~operand_b;
                carry_in = 1'b1;
            end
            OP_ADC:
            begin
                arith    = 1'b1;
                carry_in = flags_old.c;
            end
            OP_SBC:
            begin
                arith    = 1'b1;
                b_eff    = ~operand_b;
                carry_in = flags_old.c;
            end
            OP_AND:   logic_res = operand_a & operand_b;
            OP_OR:    logic_res = operand_a | operand_b;
            OP_XOR:   logic_res = operand_a ^ operand_b;
            OP_LSL:   logic_res = big_shift ? '0 : (operand_a << shamt);
            OP_LSR:   logic_res = big_shift ? '0 : (operand_a >> shamt);
            OP_ASR:
            begin
                if (big_shift)
                begin
                    logic_res = {16{operand_a[15]}};
                end
                else
                begin
                    logic_res = $unsigned($signed(operand_a) >>> shamt);
                end
            end
            OP_MOVL:  logic_res = (operand_a & HIGH_BYTE) | (operand_b & LOW_BYTE);
            OP_MOVH:  logic_res = {operand_b[7:0], operand_a[7:0]};
            OP_PASSB: logic_res = operand_b;
            OP_PASSA: logic_res = operand_a;
            default:  logic_res = '0;
        endcase
    end

    assign sum    = {1'b0, operand_a} + {1'b0, b_eff} + {16'd0, carry_in};
    assign result = arith ? sum[15:0] : logic_res;

    always_comb
    begin
        flags_new = flags_old;
        if (update_flags)
        begin
            flags_new.n = result[15];
            flags_new.z = (result == 16'd0);
            flags_new.c = arith & sum[16];
            flags_new.v = arith & (operand_a[15] == b_eff[15]) & (result[15] != operand_a[15]);
        end
    end

    always_comb
    begin
        unique case (condition)
            COND_EQ: cond_holds = flags_old.z;
            COND_NE: cond_holds = ~flags_old.z;
            COND_GE: cond_holds = (flags_old.n == flags_old.v);
            COND_GT: cond_holds = ~flags_old.z & (flags_old.n == flags_old.v);
            COND_LT: cond_holds = (flags_old.n != flags_old.v);
            COND_LE: cond_holds = flags_old.z | (flags_old.n != flags_old.v);
            COND_CS: cond_holds = flags_old.c;
            COND_CC: cond_holds = ~flags_old.c;
            default: cond_holds = 1'b0;
        endcase
    end

endmodule

// ----- src/alu16_with_flags_top.sv -----
// Top level of the 16-bit ALU with N, Z, C and V flags: input register,
// execute logic, status flag register and result register.
// Depends on alu16f_pkg and alu16f_exec.
//
// Usage: one transaction on the input channel carries an operation, two
// operands, a set-flags bit and a condition code. Each input transaction
// gives exactly one output transaction with the result, the flags after the
// operation and whether the condition held on the flags before it.
// The transaction is captured in the input register, worked through the
// execute logic and the flag register, and presented from the result
// register. Throughput is one transaction per cycle while the receiver
// does not stall, set by the loop through the status flag register.
// When the receiver stalls, the result register holds its contents and the
// input register may still take one more transaction; further input is then
// stalled until the output moves. Reset clears both valid bits and all four
// flags.
module alu16_with_flags_top
    import alu16f_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  alu_function,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic        update_flags,
    input  logic [2:0]  condition,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result_value,
    output logic        flag_n,
    output logic        flag_z,
    output logic        flag_c,
    output logic        flag_v,
    output logic        condition_true
);

    logic        in_valid_reg;
    logic [3:0]  func_reg;
    logic [15:0] a_reg;
    logic [15:0] b_reg;
    logic        upd_reg;
    logic [2:0]  cond_reg;

    flags_t      flags_reg;
    flags_t      flags_next;

    logic        out_valid_reg;
    logic [15:0] result_reg;
    flags_t      out_flags_reg;
    logic        cond_true_reg;

    logic [15:0] exec_result;
    logic        exec_cond;
    logic        advance;
    logic        in_take;

    assign advance  = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = in_valid_reg & ~advance;
    assign in_take  = in_valid & ~in_stall;

    alu16f_exec u_exec (
        .alu_function (func_reg),
        .operand_a    (a_reg),
        .operand_b    (b_reg),
        .update_flags (upd_reg),
        .condition    (cond_reg),
        .flags_old    (flags_reg),
        .result       (exec_result),
        .flags_new    (flags_next),
        .cond_holds   (exec_cond)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= alu_function;
            a_reg    <= operand_a;
            b_reg    <= operand_b;
            upd_reg  <= update_flags;
            cond_reg <= condition;
        end
        if (advance)
        begin
            result_reg    <= exec_result;
            out_flags_reg <= flags_next;
            cond_true_reg <= exec_cond;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_value   = result_reg;
    assign flag_n         = out_flags_reg.n;
    assign flag_z         = out_flags_reg.z;
    assign flag_c         = out_flags_reg.c;
    assign flag_v         = out_flags_reg.v;
    assign condition_true = cond_true_reg;

endmodule

// ----- tb/alu16_with_flags_top_test.sv -----
// Testbench for alu16_with_flags_top: directed and random ALU transactions, each result
// checked field by field against a flag-tracking model of the ALU kept in the testbench.
// Depends on alu16f_pkg and the alu16_with_flags_top RTL.
module alu16_with_flags_top_test;
    import alu16f_pkg::*;

    localparam logic [3:0] OP_UNDEF       = 4'd15;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 6;

    typedef struct packed {
        logic [15:0] value;
        flags_t      flags;
        logic        cond_ok;
    } alu_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  alu_function;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        update_flags;
    logic [2:0]  condition;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] result_value;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic        condition_true;

    alu_result_t pending_results[$];
    flags_t      model_flags  = '0;
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    int          error_count  = 0;
    int          quiet_cycles = 0;

    alu16_with_flags_top i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic alu_result_t alu_step(logic [3:0] op, logic [15:0] a, logic [15:0] b,
                                             logic upd, logic [2:0] cnd);
        alu_result_t r;
        flags_t      f;
        logic [15:0] bx;
        logic [16:0] sum;
        logic        cin;
        logic        arith;
        f       = model_flags;
        bx      = b;
        cin     = 1'b0;
        arith   = 1'b0;
        r.value = '0;
        case (cond_t'(cnd))
            COND_EQ: r.cond_ok = f.z;
            COND_NE: r.cond_ok = !f.z;
            COND_GE: r.cond_ok = (f.n == f.v);
            COND_GT: r.cond_ok = !f.z && (f.n == f.v);
            COND_LT: r.cond_ok = (f.n != f.v);
            COND_LE: r.cond_ok = f.z || (f.n != f.v);
            COND_CS: r.cond_ok = f.c;
            default: r.cond_ok = !f.c;
        endcase
        case (alu_func_t'(op))
            OP_ADD:
                arith = 1'b1;
            OP_SUB:
            begin
                arith = 1'b1;
                bx    = ~b;
                cin   = 1'b1;
            end
            OP_ADC:
            begin
                arith = 1'b1;
                cin   = f.c;
            end
            OP_SBC:
            begin
                arith = 1'b1;
                bx    = ~b;
                cin   = f.c;
            end
            OP_AND:   r.value = a & b;
            OP_OR:    r.value = a | b;
            OP_XOR:   r.value = a ^ b;
            OP_LSL:   r.value = (b >= 16) ? 16'h0000 : (a << b[3:0]);
            OP_LSR:   r.value = (b >= 16) ? 16'h0000 : (a >> b[3:0]);
            OP_ASR:   r.value = (b >= 16) ? {16{a[15]}} : $unsigned($signed(a) >>> b[3:0]);
            OP_MOVL:  r.value = (a & HIGH_BYTE) | (b & LOW_BYTE);
            OP_MOVH:  r.value = (a & LOW_BYTE) | {b[7:0], 8'h00};
            OP_PASSB: r.value = b;
            OP_PASSA: r.value = a;
            default:  r.value = '0;
        endcase
        sum = {1'b0, a} + {1'b0, bx} + {16'd0, cin};
        if (arith)
            r.value = sum[15:0];
        if (upd)
        begin
            f.n = r.value[15];
            f.z = (r.value == 16'h0000);
            f.c = arith && sum[16];
            f.v = arith && (a[15] == bx[15]) && (r.value[15] != a[15]);
        end
        model_flags = f;
        r.flags     = f;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        alu_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, got %h",
                         $time, result_value);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_value", want.value, result_value);
                check_field("flag_n", 16'(want.flags.n), 16'(flag_n));
                check_field("flag_z", 16'(want.flags.z), 16'(flag_z));
                check_field("flag_c", 16'(want.flags.c), 16'(flag_c));
                check_field("flag_v", 16'(want.flags.v), 16'(flag_v));
                check_field("condition_true", 16'(want.cond_ok), 16'(condition_true));
            end
        end
        if (rst_n && in_valid && !in_stall)
            pending_results.push_back(alu_step(alu_function, operand_a, operand_b,
                                               update_flags, condition));
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("alu16_with_flags_top_test: done, errors");
            $finish;
        end
    end

    task automatic send_op(logic [3:0] op, logic [15:0] a, logic [15:0] b, logic upd,
                           logic [2:0] cnd);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        alu_function <= op;
        operand_a    <= a;
        operand_b    <= b;
        update_flags <= upd;
        condition    <= cnd;
        in_valid     <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    function automatic logic [15:0] corner_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_arith_carry_overflow();
        send_op(OP_ADD, 16'hFFFF, 16'h0001, 1'b1, COND_EQ);
        send_op(OP_ADC, 16'h7FFF, 16'h0000, 1'b1, COND_CS);
        send_op(OP_SUB, 16'h8000, 16'h0001, 1'b1, COND_GE);
        send_op(OP_SBC, 16'h0000, 16'hFFFF, 1'b1, COND_LT);
        send_op(OP_SBC, 16'h0000, 16'h0000, 1'b1, COND_CC);
        send_op(OP_ADD, 16'h0000, 16'h0000, 1'b1, COND_GT);
    endtask

    task automatic test_logic_and_moves();
        send_op(OP_AND, 16'hFFFF, 16'h00FF, 1'b1, COND_EQ);
        send_op(OP_OR, 16'h8000, 16'h0001, 1'b1, COND_NE);
        send_op(OP_XOR, 16'hFFFF, 16'hFFFF, 1'b1, COND_LE);
        send_op(OP_MOVL, 16'hA5C3, 16'h5AFF, 1'b1, COND_EQ);
        send_op(OP_MOVH, 16'hFFFF, 16'hFFFF, 1'b1, COND_GE);
        send_op(OP_PASSB, 16'h0000, 16'h8000, 1'b1, COND_LT);
        send_op(OP_PASSA, 16'h7FFF, 16'hFFFF, 1'b1, COND_GT);
        send_op(OP_NONE, 16'hFFFF, 16'hFFFF, 1'b1, COND_NE);
        send_op(OP_UNDEF, 16'hFFFF, 16'hFFFF, 1'b1, COND_EQ);
    endtask

    task automatic test_shift_ranges();
        send_op(OP_LSL, 16'h0001, 16'h000F, 1'b1, COND_LT);
        send_op(OP_LSR, 16'h8000, 16'h0010, 1'b1, COND_EQ);
        send_op(OP_ASR, 16'h8000, 16'h0001, 1'b1, COND_LE);
        send_op(OP_ASR, 16'h8000, 16'hFFFF, 1'b1, COND_CC);
        send_op(OP_ASR, 16'h7FFF, 16'h0010, 1'b1, COND_EQ);
        send_op(OP_LSL, 16'hFFFF, 16'h0000, 1'b1, COND_CS);
    endtask

    task automatic test_flags_held();
        send_op(OP_ADD, 16'h7FFF, 16'h0001, 1'b0, COND_LE);
    endtask

    task automatic test_random(int count);
        logic [3:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        for (int i = 0; i < count; i++)
        begin
            op = 4'($urandom_range(15));
            a  = corner_word();
            b  = corner_word();
            if (op >= OP_LSL && op <= OP_ASR && $urandom_range(3) != 0)
                b = 16'($urandom_range(20));
            else if ($urandom_range(7) == 0)
                b = a;
            send_op(op, a, b, 1'($urandom_range(1)), 3'($urandom_range(7)));
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        alu_function <= OP_NONE;
        operand_a    <= '0;
        operand_b    <= '0;
        update_flags <= 1'b0;
        condition    <= COND_EQ;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 10;
        rx_idle_pct = 48;
        test_arith_carry_overflow();
        test_logic_and_moves();
        test_shift_ranges();
        test_flags_held();
        test_random(230);

        tx_idle_pct = 48;
        rx_idle_pct = 10;
        test_random(115);
        wait_for_results();
        test_random(115);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(230);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("alu16_with_flags_top_test: done, clean");
        else
            $display("alu16_with_flags_top_test: done, errors");
        $finish;
    end

endmodule
